// ----- hdl/ccs_pkg.sv -----
package ccs_pkg;

  localparam int unsigned CfgIdxW  = 3;
  localparam int unsigned CfgDataW = 8;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_ACTIVE_UNITS  = 3'd0,
    CFG_PAUSE_UNITS   = 3'd1,
    CFG_CHANNEL_COUNT = 3'd2,
    CFG_TICKS_ON      = 3'd3,
    CFG_TICKS_OFF     = 3'd4
  } cfg_reg_e;

  localparam logic [7:0] TicksOnRst  = 8'd5;
  localparam logic [7:0] TicksOffRst = 8'd50;

  typedef struct packed {
    logic [6:0] active_units;
    logic [6:0] pause_units;
    logic [4:0] channel_count;
    logic [7:0] ticks_on;
    logic [7:0] ticks_off;
  } cfg_t;

  typedef struct packed {
    logic [3:0] chan_idx;
    logic       in_off_phase;
    logic [6:0] unit_count;
    logic [7:0] tick_count;
  } state_t;

  typedef struct packed {
    logic [3:0] channel_index;
    logic       valve_on;
    logic       running;
    logic [6:0] left_tens_seg;
    logic [6:0] left_ones_seg;
    logic [6:0] right_tens_seg;
    logic [6:0] right_ones_seg;
  } result_t;

  // gfedcba encoding
  function automatic logic [6:0] seg_digit(logic [3:0] d);
    logic [6:0] s;
    case (d)
      4'd0:    s = 7'h3F;
      4'd1:    s = 7'h06;
      4'd2:    s = 7'h5B;
      4'd3:    s = 7'h4F;
      4'd4:    s = 7'h66;
      4'd5:    s = 7'h6D;
      4'd6:    s = 7'h7D;
      4'd7:    s = 7'h07;
      4'd8:    s = 7'h7F;
      4'd9:    s = 7'h6F;
      default: s = 7'h00;
    endcase
    return s;
  endfunction

  // Two-digit display, saturating at 99. {tens, ones}.
  function automatic logic [13:0] seg_pair(logic [6:0] v);
    logic [6:0]  c;
    logic [14:0] prod;
    logic [3:0]  tens;
    logic [6:0]  ones;
    c    = (v > 7'd99) ? 7'd99 : v;
    prod = 15'(c) * 15'd205;      // x/10 == (x*205)>>11 for x < 1029
    tens = prod[14:11];
    ones = c - 7'(tens) * 7'd10;
    return {seg_digit(tens), seg_digit(ones[3:0])};
  endfunction

endpackage

// ----- hdl/ccs_in_if.sv -----
interface ccs_in_if;
  logic valid;
  logic ready;
  logic tick;

  modport source (output valid, output tick, input ready);
  modport sink   (input valid, input tick, output ready);
endinterface

// ----- hdl/ccs_out_if.sv -----
interface ccs_out_if;
  logic       valid;
  logic       ready;
  logic [3:0] channel_index;
  logic       valve_on;
  logic       running;
  logic [6:0] left_tens_seg;
  logic [6:0] left_ones_seg;
  logic [6:0] right_tens_seg;
  logic [6:0] right_ones_seg;

  modport source (
    output valid, output channel_index, output valve_on, output running,
    output left_tens_seg, output left_ones_seg, output right_tens_seg,
    output right_ones_seg, input ready
  );
  modport sink (
    input valid, input channel_index, input valve_on, input running,
    input left_tens_seg, input left_ones_seg, input right_tens_seg,
    input right_ones_seg, output ready
  );
endinterface

// ----- hdl/ccs_cfg_if.sv -----
interface ccs_cfg_if;
  logic                          valid;
  logic                          ready;
  logic [ccs_pkg::CfgIdxW-1:0]   index;
  logic [ccs_pkg::CfgDataW-1:0]  data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

// ----- hdl/ccs_step.sv -----
module ccs_step #(
  parameter int unsigned MAX_CHANNELS = 16
) (
  input  ccs_pkg::cfg_t    cfg_i,
  input  ccs_pkg::state_t  state_i,
  input  logic             tick_i,
  output ccs_pkg::state_t  state_o,
  output ccs_pkg::result_t result_o
);

  localparam logic [4:0] MaxCh = 5'(MAX_CHANNELS);

  function automatic logic [3:0] next_chan(logic [3:0] c, logic [4:0] cnt);
    logic [4:0] inc;
    inc = {1'b0, c} + 5'd1;
    return (inc >= cnt) ? 4'd0 : inc[3:0];
  endfunction

  logic [4:0]      n;
  ccs_pkg::state_t s;
  logic [7:0]      tpu;
  logic [8:0]      tick_inc;
  logic [6:0]      right_val;
  logic [6:0]      left_val;
  logic [13:0]     left_pair;
  logic [13:0]     right_pair;

  always_comb begin
    n          = (cfg_i.channel_count > MaxCh) ? MaxCh : cfg_i.channel_count;
    s          = state_i;
    state_o    = '0;
    result_o   = '0;
    tpu        = '0;
    tick_inc   = '0;
    left_val   = '0;
    right_val  = '0;

    // channel count lowered under the current channel: restart
    if ({1'b0, s.chan_idx} >= n) begin
      s = '0;
    end

    if (cfg_i.active_units == 7'd0 && cfg_i.pause_units == 7'd0) begin
      right_val        = {3'b000, s.chan_idx} + 7'd1;
      state_o          = '0;
      state_o.chan_idx = tick_i ? next_chan(s.chan_idx, n) : s.chan_idx;
    end else begin
      // settle finished or empty phases
      if (!s.in_off_phase && s.unit_count >= cfg_i.active_units) begin
        s.in_off_phase = 1'b1;
        s.unit_count   = '0;
        s.tick_count   = '0;
      end
      if (s.in_off_phase && s.unit_count >= cfg_i.pause_units) begin
        s.chan_idx     = next_chan(s.chan_idx, n);
        s.in_off_phase = 1'b0;
        s.unit_count   = '0;
        s.tick_count   = '0;
      end
      if (!s.in_off_phase && s.unit_count >= cfg_i.active_units) begin
        s.in_off_phase = 1'b1;
        s.unit_count   = '0;
        s.tick_count   = '0;
      end

      if (!s.in_off_phase) begin
        right_val = {3'b000, s.chan_idx} + 7'd1;
      end else begin
        left_val  = cfg_i.pause_units - s.unit_count;
        right_val = ({1'b0, s.chan_idx} + 5'd1 >= n) ? 7'd1
                                                     : {3'b000, s.chan_idx} + 7'd2;
      end

      if (tick_i) begin
        tpu = s.in_off_phase ? cfg_i.ticks_off : cfg_i.ticks_on;
        if (tpu == 8'd0) begin
          tpu = 8'd1;
        end
        tick_inc = {1'b0, s.tick_count} + 9'd1;
        if (tick_inc >= {1'b0, tpu}) begin
          s.tick_count = '0;
          s.unit_count = s.unit_count + 7'd1;
        end else begin
          s.tick_count = tick_inc[7:0];
        end
      end
      state_o = s;
    end

    left_pair  = ccs_pkg::seg_pair(left_val);
    right_pair = ccs_pkg::seg_pair(right_val);

    if (n != 5'd0) begin
      result_o.channel_index  = s.chan_idx;
      result_o.valve_on       = !s.in_off_phase &&
                                !(cfg_i.active_units == 7'd0 && cfg_i.pause_units == 7'd0);
      result_o.running        = 1'b1;
      result_o.left_tens_seg  = left_pair[13:7];
      result_o.left_ones_seg  = left_pair[6:0];
      result_o.right_tens_seg = right_pair[13:7];
      result_o.right_ones_seg = right_pair[6:0];
    end else begin
      state_o = '0;
    end
  end

endmodule

// ----- hdl/channel_cycle_sequencer.sv -----
// Channel cycle sequencer. Every accepted tick transaction yields exactly one
// result transaction, registered, in the cycle after acceptance. A tick can be
// accepted every clock cycle: the sequencing state and the display decode are
// updated in a single combinational pass between the state registers and the
// output register, and the input is ready whenever the output register is
// empty or being drained. Configuration writes take effect on the next cycle
// and should only be issued while no result is outstanding.
module channel_cycle_sequencer #(
  parameter int unsigned MAX_CHANNELS = 16
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  ccs_cfg_if.sink   cfg_i,
  ccs_in_if.sink    in_i,
  ccs_out_if.source out_o
);

  ccs_pkg::cfg_t    cfg_q;
  ccs_pkg::state_t  state_q, state_d;
  ccs_pkg::result_t res_q, res_d;
  logic             out_valid_q;
  logic             in_fire;

  assign cfg_i.ready = 1'b1;
  assign in_i.ready  = !out_valid_q || out_o.ready;
  assign in_fire     = in_i.valid && in_i.ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.active_units  <= '0;
      cfg_q.pause_units   <= '0;
      cfg_q.channel_count <= '0;
      cfg_q.ticks_on      <= ccs_pkg::TicksOnRst;
      cfg_q.ticks_off     <= ccs_pkg::TicksOffRst;
    end else if (cfg_i.valid) begin
      unique case (cfg_i.index)
        ccs_pkg::CFG_ACTIVE_UNITS:  cfg_q.active_units  <= cfg_i.data[6:0];
        ccs_pkg::CFG_PAUSE_UNITS:   cfg_q.pause_units   <= cfg_i.data[6:0];
        ccs_pkg::CFG_CHANNEL_COUNT: cfg_q.channel_count <= cfg_i.data[4:0];
        ccs_pkg::CFG_TICKS_ON:      cfg_q.ticks_on      <= cfg_i.data;
        ccs_pkg::CFG_TICKS_OFF:     cfg_q.ticks_off     <= cfg_i.data;
        default: ;
      endcase
    end
  end

  ccs_step #(
    .MAX_CHANNELS(MAX_CHANNELS)
  ) u_step (
    .cfg_i   (cfg_q),
    .state_i (state_q),
    .tick_i  (in_i.tick),
    .state_o (state_d),
    .result_o(res_d)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (in_fire) begin
        state_q <= state_d;
      end
      if (in_fire) begin
        out_valid_q <= 1'b1;
      end else if (out_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      res_q <= res_d;
    end
  end

  assign out_o.valid          = out_valid_q;
  assign out_o.channel_index  = res_q.channel_index;
  assign out_o.valve_on       = res_q.valve_on;
  assign out_o.running        = res_q.running;
  assign out_o.left_tens_seg  = res_q.left_tens_seg;
  assign out_o.left_ones_seg  = res_q.left_ones_seg;
  assign out_o.right_tens_seg = res_q.right_tens_seg;
  assign out_o.right_ones_seg = res_q.right_ones_seg;

  // tick counter always wraps before reaching its all-ones value
  a_tick_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q.tick_count != 8'hFF)
    else $error("tick counter out of range");

  a_fire_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_fire |=> out_o.valid)
    else $error("accepted transaction produced no result");

  a_idle_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_fire && cfg_q.channel_count == 5'd0 |=> state_q == '0)
    else $error("idle did not clear state");

  a_idle_blank: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_o.valid && !out_o.running |-> out_o.channel_index == 4'd0 && !out_o.valve_on
      && out_o.left_tens_seg == 7'd0 && out_o.right_ones_seg == 7'd0)
    else $error("idle result not blank");

  a_valve_digit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_o.valid && out_o.valve_on |-> out_o.left_tens_seg == 7'h3F
      && out_o.left_ones_seg == 7'h3F)
    else $error("left display not zero during on phase");

endmodule

// ----- tb/sv/testbench.sv -----
module testbench;

  localparam int MaxChannels = 16;
  localparam int CfgRegCount = 5;
  localparam int CycleLimit  = 200000;
  localparam int RandomPhases = 16;
  localparam int PhaseItems   = 97;
  localparam int IdxW         = ccs_pkg::CfgIdxW;
  localparam int DataW        = ccs_pkg::CfgDataW;

  logic clk_i  = 1'b0;
  logic rst_ni = 1'b0;

  ccs_cfg_if cfg_if ();
  ccs_in_if  in_if ();
  ccs_out_if out_if ();

  channel_cycle_sequencer dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cfg_i  (cfg_if),
    .in_i   (in_if),
    .out_o  (out_if)
  );

  always #2 clk_i = ~clk_i;

  // Predictor copy of the register file
  logic [6:0] cfg_active;
  logic [6:0] cfg_pause;
  logic [4:0] cfg_channels;
  logic [7:0] cfg_ticks_on;
  logic [7:0] cfg_ticks_off;

  // Predictor copy of the sequencing state
  logic [3:0] seq_chan;
  logic       seq_off;
  logic [6:0] seq_units;
  logic [7:0] seq_ticks;

  bit               tick_backlog[$];
  ccs_pkg::result_t expected_frames[$];

  int  src_idle_pct;
  int  snk_stall_pct;
  bit  in_taken;
  int  cycle_count;
  int  error_count;

  task automatic report_mismatch(string msg);
    $display("ERROR cycle %0d: %s", cycle_count, msg);
    error_count++;
  endtask

  task automatic check_field(string name, logic [6:0] got, logic [6:0] want);
    if (got !== want) begin
      report_mismatch($sformatf("%s got 0x%0h want 0x%0h", name, got, want));
    end
  endtask

  function automatic logic [6:0] digit_seg(int d);
    case (d)
      0:       return 7'h3F;
      1:       return 7'h06;
      2:       return 7'h5B;
      3:       return 7'h4F;
      4:       return 7'h66;
      5:       return 7'h6D;
      6:       return 7'h7D;
      7:       return 7'h07;
      8:       return 7'h7F;
      default: return 7'h6F;
    endcase
  endfunction

  // {tens, ones} for a value clamped at 99
  function automatic logic [13:0] two_digits(int v);
    int c;
    c = (v > 99) ? 99 : v;
    return {digit_seg(c / 10), digit_seg(c % 10)};
  endfunction

  function automatic void restart_phase(logic off);
    seq_off   = off;
    seq_units = '0;
    seq_ticks = '0;
  endfunction

  function automatic ccs_pkg::result_t sequence_tick(bit tick);
    int               n;
    int               upcoming;
    int               tpu;
    ccs_pkg::result_t r;
    r = '0;
    n = (int'(cfg_channels) > MaxChannels) ? MaxChannels : int'(cfg_channels);
    if (n == 0) begin
      seq_chan = '0;
      restart_phase(1'b0);
      return r;
    end
    if (int'(seq_chan) >= n) begin
      seq_chan = '0;
      restart_phase(1'b0);
    end
    r.channel_index = seq_chan;
    r.running       = 1'b1;
    if (cfg_active == 0 && cfg_pause == 0) begin
      // both phases empty: one step per channel, valve stays closed
      restart_phase(1'b0);
      {r.left_tens_seg, r.left_ones_seg}   = two_digits(0);
      {r.right_tens_seg, r.right_ones_seg} = two_digits(int'(seq_chan) + 1);
      if (tick) begin
        seq_chan = 4'((int'(seq_chan) + 1) % n);
      end
      return r;
    end
    // skip finished or empty phases
    if (!seq_off && seq_units >= cfg_active) begin
      restart_phase(1'b1);
    end
    if (seq_off && seq_units >= cfg_pause) begin
      seq_chan = 4'((int'(seq_chan) + 1) % n);
      restart_phase(1'b0);
    end
    if (!seq_off && seq_units >= cfg_active) begin
      restart_phase(1'b1);
    end
    upcoming = (int'(seq_chan) + 1 >= n) ? 1 : int'(seq_chan) + 2;
    r.channel_index = seq_chan;
    r.valve_on      = !seq_off;
    if (!seq_off) begin
      {r.left_tens_seg, r.left_ones_seg}   = two_digits(0);
      {r.right_tens_seg, r.right_ones_seg} = two_digits(int'(seq_chan) + 1);
    end else begin
      {r.left_tens_seg, r.left_ones_seg}   = two_digits(int'(cfg_pause) - int'(seq_units));
      {r.right_tens_seg, r.right_ones_seg} = two_digits(upcoming);
    end
    if (tick) begin
      tpu = seq_off ? int'(cfg_ticks_off) : int'(cfg_ticks_on);
      if (tpu == 0) begin
        tpu = 1;
      end
      seq_ticks = seq_ticks + 8'd1;
      if (int'(seq_ticks) >= tpu) begin
        seq_ticks = '0;
        seq_units = seq_units + 7'd1;
      end
    end
    return r;
  endfunction

  // Monitor: register writes, result checks, predictions, cycle limit
  always @(posedge clk_i) begin
    ccs_pkg::result_t want;
    in_taken = rst_ni && in_if.valid && in_if.ready;
    if (rst_ni) begin
      if (cfg_if.valid && cfg_if.ready) begin
        case (cfg_if.index)
          ccs_pkg::CFG_ACTIVE_UNITS:  cfg_active    = cfg_if.data[6:0];
          ccs_pkg::CFG_PAUSE_UNITS:   cfg_pause     = cfg_if.data[6:0];
          ccs_pkg::CFG_CHANNEL_COUNT: cfg_channels  = cfg_if.data[4:0];
          ccs_pkg::CFG_TICKS_ON:      cfg_ticks_on  = cfg_if.data;
          ccs_pkg::CFG_TICKS_OFF:     cfg_ticks_off = cfg_if.data;
          default: ;
        endcase
      end
      if (out_if.valid && out_if.ready) begin
        if (expected_frames.size() == 0) begin
          report_mismatch("result transaction with no expectation pending");
        end else begin
          want = expected_frames.pop_front();
          check_field("channel_index", 7'(out_if.channel_index), 7'(want.channel_index));
          check_field("valve_on", 7'(out_if.valve_on), 7'(want.valve_on));
          check_field("running", 7'(out_if.running), 7'(want.running));
          check_field("left_tens_seg", out_if.left_tens_seg, want.left_tens_seg);
          check_field("left_ones_seg", out_if.left_ones_seg, want.left_ones_seg);
          check_field("right_tens_seg", out_if.right_tens_seg, want.right_tens_seg);
          check_field("right_ones_seg", out_if.right_ones_seg, want.right_ones_seg);
        end
      end
      if (in_taken) begin
        expected_frames.push_back(sequence_tick(in_if.tick));
      end
    end
    cycle_count++;
    if (cycle_count >= CycleLimit) begin
      $display("ERROR: timeout after %0d cycles", cycle_count);
      $display("CHECKS FAILED");
      $finish;
    end
  end

  // Driver: tick transactions and result back-pressure
  always @(negedge clk_i) begin
    if (!in_if.valid || in_taken) begin
      if (tick_backlog.size() != 0 && $urandom_range(99) >= src_idle_pct) begin
        in_if.valid <= 1'b1;
        in_if.tick  <= tick_backlog.pop_front();
      end else begin
        in_if.valid <= 1'b0;
      end
    end
    out_if.ready <= ($urandom_range(99) >= snk_stall_pct);
  end

  task automatic write_reg(logic [IdxW-1:0] idx, logic [DataW-1:0] value);
    @(negedge clk_i);
    cfg_if.valid <= 1'b1;
    cfg_if.index <= idx;
    cfg_if.data  <= value;
    do @(posedge clk_i); while (cfg_if.ready !== 1'b1);
  endtask

  task automatic configure(logic [7:0] active, logic [7:0] pause, logic [7:0] chans,
                           logic [7:0] ton, logic [7:0] toff);
    logic [IdxW-1:0] spare_idx;
    write_reg(ccs_pkg::CFG_ACTIVE_UNITS, active);
    write_reg(ccs_pkg::CFG_PAUSE_UNITS, pause);
    write_reg(ccs_pkg::CFG_CHANNEL_COUNT, chans);
    write_reg(ccs_pkg::CFG_TICKS_ON, ton);
    write_reg(ccs_pkg::CFG_TICKS_OFF, toff);
    // unmapped index, must be ignored
    if ($urandom_range(3) == 0) begin
      spare_idx = IdxW'($urandom_range(CfgRegCount, 2 ** IdxW - 1));
      write_reg(spare_idx, DataW'($urandom_range(255)));
    end
    @(negedge clk_i);
    cfg_if.valid <= 1'b0;
  endtask

  task automatic enqueue_ticks(int count, int one_pct);
    @(posedge clk_i);
    repeat (count) tick_backlog.push_back($urandom_range(99) < one_pct);
  endtask

  task automatic wait_drained();
    while (tick_backlog.size() != 0 || in_if.valid || expected_frames.size() != 0)
      @(posedge clk_i);
    repeat (2) @(posedge clk_i);
  endtask

  function automatic logic [7:0] pick_length();
    case ($urandom_range(9))
      0:       return 8'd0;
      1:       return 8'($urandom_range(255));
      default: return 8'($urandom_range(1, 4));
    endcase
  endfunction

  function automatic logic [7:0] pick_ticks();
    case ($urandom_range(9))
      0:       return 8'd0;
      1:       return 8'($urandom_range(255));
      default: return 8'($urandom_range(1, 3));
    endcase
  endfunction

  initial begin
    logic [7:0] chans;
    cfg_if.valid  = 1'b0;
    cfg_if.index  = ccs_pkg::CFG_ACTIVE_UNITS;
    cfg_if.data   = '0;
    in_if.valid   = 1'b0;
    in_if.tick    = 1'b0;
    out_if.ready  = 1'b0;
    src_idle_pct  = 0;
    snk_stall_pct = 0;
    in_taken      = 1'b0;
    cycle_count   = 0;
    error_count   = 0;
    cfg_active    = '0;
    cfg_pause     = '0;
    cfg_channels  = '0;
    cfg_ticks_on  = ccs_pkg::TicksOnRst;
    cfg_ticks_off = ccs_pkg::TicksOffRst;
    seq_chan      = '0;
    restart_phase(1'b0);

    repeat (2) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // idle after reset: display blank
    @(posedge clk_i);
    tick_backlog.push_back(1'b1);
    tick_backlog.push_back(1'b0);
    wait_drained();

    // plain on/off sequence over three channels; the upcoming channel shown wraps to 1
    configure(8'd2, 8'd1, 8'd3, 8'd1, 8'd2);
    enqueue_ticks(12, 100);
    wait_drained();

    // channel count above maximum, both phases empty, zero ticks per unit
    configure(8'd0, 8'd0, 8'd31, 8'd0, 8'd0);
    @(posedge clk_i);
    tick_backlog.push_back(1'b1);
    tick_backlog.push_back(1'b0);
    tick_backlog.push_back(1'b1);
    tick_backlog.push_back(1'b1);
    wait_drained();

    // empty on phase, long off phase clamps the countdown at 99
    configure(8'd0, 8'd127, 8'd2, 8'd255, 8'd0);
    enqueue_ticks(3, 100);
    wait_drained();

    // channel count lowered to one, empty off phase
    configure(8'd1, 8'd0, 8'd1, 8'd1, 8'd1);
    enqueue_ticks(3, 100);
    wait_drained();

    // top bits of the data bus on narrow registers
    configure(8'hFF, 8'd99, 8'd16, 8'd255, 8'd1);
    enqueue_ticks(2, 100);
    wait_drained();

    for (int ph = 0; ph < RandomPhases; ph++) begin
      case (ph % 4)
        0: begin src_idle_pct = 0;  snk_stall_pct = 0;  end
        1: begin src_idle_pct = 63; snk_stall_pct = 0;  end
        2: begin src_idle_pct = 0;  snk_stall_pct = 63; end
        default: begin src_idle_pct = 34; snk_stall_pct = 34; end
      endcase
      case ($urandom_range(9))
        0:       chans = 8'd0;
        1:       chans = 8'($urandom_range(17, 31));
        2:       chans = 8'd16;
        3:       chans = 8'($urandom_range(255));
        default: chans = 8'($urandom_range(1, 6));
      endcase
      configure(pick_length(), pick_length(), chans, pick_ticks(), pick_ticks());
      enqueue_ticks(PhaseItems, 80);
      wait_drained();
    end

    if (error_count == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

// ----- files.f -----
hdl/ccs_pkg.sv
hdl/ccs_in_if.sv
hdl/ccs_out_if.sv
hdl/ccs_cfg_if.sv
hdl/ccs_step.sv
hdl/channel_cycle_sequencer.sv
tb/sv/testbench.sv
